FILE: rtl/mbe_pkg.sv
`default_nettype none
// ============================================================================
// mbe_pkg
// Shared types, constants and a helper function for the escape-time evaluator.
// ============================================================================
package mbe_pkg;

  localparam int PIXEL_INDEX_BITS = 10;
  localparam int Q_FRAC           = 28;
  localparam int COORD_W          = 32;
  localparam int STEP_W           = 31;
  localparam int COUNT_W          = 16;
  localparam int GREEN_W          = 8;
  localparam int SQ_W             = 36;
  localparam int SUM_W            = 48;
  localparam int PROD_W           = PIXEL_INDEX_BITS + STEP_W;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_X         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

  localparam logic signed [COORD_W-1:0] ORIGIN_X_RESET = -32'sd590558003;
  localparam logic signed [COORD_W-1:0] ORIGIN_Y_RESET = -32'sd429496730;
  localparam logic [STEP_W-1:0]         STEP_X_RESET   = 31'd1342177;
  localparam logic [STEP_W-1:0]         STEP_Y_RESET   = 31'd1342177;
  localparam logic [COUNT_W-1:0]        MAX_ITER_RESET = 16'd100;

  localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(64'd4 << Q_FRAC);

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [COUNT_W-1:0]        max_iterations;
  } config_t;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] col;
    logic [PIXEL_INDEX_BITS-1:0] row;
    logic signed [COORD_W-1:0]   cx;
    logic signed [COORD_W-1:0]   cy;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    lo = {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mbe_queue.sv
`default_nettype none
// ============================================================================
// mbe_queue
// Short queue of mapped points between the front end and the iteration engine.
// ============================================================================
module mbe_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire mbe_pkg::item_t         push_item,
  input  wire logic                   pop,
  output mbe_pkg::item_t              pop_item,
  output mbe_pkg::queue_status_t      status
);

  mbe_pkg::item_t                    entries [mbe_pkg::QUEUE_DEPTH];
  logic [mbe_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [mbe_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [mbe_pkg::QUEUE_CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_item     = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == mbe_pkg::QUEUE_CNT_W'(mbe_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

FILE: rtl/mbe_front.sv
`default_nettype none
// ============================================================================
// mbe_front
// Accepts pixel commands and maps each pixel to its point c in Q4.28.
// ============================================================================
module mbe_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] pixel_column,
  input  wire logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] pixel_row,
  input  wire mbe_pkg::config_t                     cfg,
  input  wire mbe_pkg::queue_status_t               qstat,
  output logic                                      busy,
  output logic                                      push,
  output mbe_pkg::item_t                            push_item
);

  logic                                 accept;
  logic                                 s1_valid;
  logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] s1_col;
  logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] s1_row;
  logic [mbe_pkg::PROD_W-1:0]           s1_prod_x;
  logic [mbe_pkg::PROD_W-1:0]           s1_prod_y;
  logic signed [mbe_pkg::SUM_W-1:0]     sum_x;
  logic signed [mbe_pkg::SUM_W-1:0]     sum_y;

  assign busy   = rst | s1_valid | qstat.full;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= pixel_column;
      s1_row    <= pixel_row;
      s1_prod_x <= mbe_pkg::PROD_W'(pixel_column) * mbe_pkg::PROD_W'(cfg.step_x);
      s1_prod_y <= mbe_pkg::PROD_W'(pixel_row) * mbe_pkg::PROD_W'(cfg.step_y);
    end
  end

  assign sum_x = mbe_pkg::SUM_W'(cfg.origin_x) + mbe_pkg::SUM_W'($signed({1'b0, s1_prod_x}));
  assign sum_y = mbe_pkg::SUM_W'(cfg.origin_y) + mbe_pkg::SUM_W'($signed({1'b0, s1_prod_y}));

  assign push         = s1_valid;
  assign push_item.col = s1_col;
  assign push_item.row = s1_row;
  assign push_item.cx  = mbe_pkg::sat_coord(sum_x);
  assign push_item.cy  = mbe_pkg::sat_coord(sum_y);

endmodule
`default_nettype wire

FILE: rtl/mbe_back.sv
`default_nettype none
// ============================================================================
// mbe_back
// Iteration engine: runs z = z^2 + c, then scales the count to a green level
// with a bit-serial divider.
// ============================================================================
module mbe_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire mbe_pkg::config_t                      cfg,
  input  wire mbe_pkg::queue_status_t                qstat,
  input  wire mbe_pkg::item_t                        pop_item,
  output logic                                       pop,
  output logic                                       done,
  output logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]       out_column,
  output logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]       out_row,
  output logic [mbe_pkg::COUNT_W-1:0]                iteration_count,
  output logic [mbe_pkg::GREEN_W-1:0]                green_level
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TEST   = 2'd1;
  localparam logic [1:0] ST_SQUARE = 2'd2;
  localparam logic [1:0] ST_DIVIDE = 2'd3;

  localparam int REM_W = mbe_pkg::COUNT_W + mbe_pkg::GREEN_W;
  localparam int BIT_W = $clog2(mbe_pkg::GREEN_W);

  function automatic logic [mbe_pkg::COORD_W-1:0] abs_clamp(
    input logic signed [mbe_pkg::COORD_W:0] v
  );
    logic [mbe_pkg::COORD_W:0] m;
    m = v[mbe_pkg::COORD_W] ? (~v + 1'b1) : v;
    if (m[mbe_pkg::COORD_W]) begin
      return '1;
    end
    return m[mbe_pkg::COORD_W-1:0];
  endfunction

  function automatic logic [mbe_pkg::SQ_W-1:0] square_q(
    input logic [mbe_pkg::COORD_W-1:0] m
  );
    logic [2*mbe_pkg::COORD_W-1:0] p;
    p = (2*mbe_pkg::COORD_W)'(m) * (2*mbe_pkg::COORD_W)'(m);
    return p[mbe_pkg::Q_FRAC +: mbe_pkg::SQ_W];
  endfunction

  logic [1:0]                           state;
  logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] col;
  logic [mbe_pkg::PIXEL_INDEX_BITS-1:0] row;
  logic signed [mbe_pkg::COORD_W-1:0]   cx;
  logic signed [mbe_pkg::COORD_W-1:0]   cy;
  logic signed [mbe_pkg::COORD_W-1:0]   x;
  logic signed [mbe_pkg::COORD_W-1:0]   y;
  logic [mbe_pkg::SQ_W-1:0]             x2;
  logic [mbe_pkg::SQ_W-1:0]             y2;
  logic [mbe_pkg::SQ_W-1:0]             w;
  logic [mbe_pkg::COUNT_W-1:0]          count;
  logic [REM_W-1:0]                     rem;
  logic [mbe_pkg::GREEN_W-1:0]          quo;
  logic [BIT_W-1:0]                     bit_idx;

  logic [mbe_pkg::SQ_W:0]               mag_sum;
  logic                                 finished;
  logic signed [mbe_pkg::SUM_W-1:0]     sum_x;
  logic signed [mbe_pkg::SUM_W-1:0]     sum_y;
  logic signed [mbe_pkg::COORD_W:0]     sum_xy;
  logic [REM_W-1:0]                     divisor_shifted;
  logic                                 take;
  logic [REM_W-1:0]                     rem_next;
  logic [mbe_pkg::GREEN_W-1:0]          quo_next;

  assign mag_sum  = {1'b0, x2} + {1'b0, y2};
  assign finished = (mag_sum > mbe_pkg::ESCAPE_LIMIT) || (count >= cfg.max_iterations);

  assign sum_x = mbe_pkg::SUM_W'(x2) - mbe_pkg::SUM_W'(y2) + mbe_pkg::SUM_W'(cx);
  assign sum_y = mbe_pkg::SUM_W'(w) - mbe_pkg::SUM_W'(x2) - mbe_pkg::SUM_W'(y2)
               + mbe_pkg::SUM_W'(cy);
  assign sum_xy = {x[mbe_pkg::COORD_W-1], x} + {y[mbe_pkg::COORD_W-1], y};

  assign divisor_shifted = REM_W'(cfg.max_iterations) << bit_idx;
  assign take            = (rem >= divisor_shifted);
  assign rem_next        = take ? (rem - divisor_shifted) : rem;
  assign quo_next        = take ? (quo | (mbe_pkg::GREEN_W'(1) << bit_idx)) : quo;

  assign pop = (state == ST_IDLE) & ~qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          state <= finished ? ST_DIVIDE : ST_SQUARE;
        end
        ST_SQUARE: begin
          state <= ST_TEST;
        end
        ST_DIVIDE: begin
          if (bit_idx == '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          col   <= pop_item.col;
          row   <= pop_item.row;
          cx    <= pop_item.cx;
          cy    <= pop_item.cy;
          x2    <= '0;
          y2    <= '0;
          w     <= '0;
          count <= '0;
        end
      end
      ST_TEST: begin
        if (finished) begin
          rem     <= {count, mbe_pkg::GREEN_W'(0)} - REM_W'(count);
          quo     <= '0;
          bit_idx <= BIT_W'(mbe_pkg::GREEN_W - 1);
        end else begin
          x     <= mbe_pkg::sat_coord(sum_x);
          y     <= mbe_pkg::sat_coord(sum_y);
          count <= count + 1'b1;
        end
      end
      ST_SQUARE: begin
        x2 <= square_q(abs_clamp({x[mbe_pkg::COORD_W-1], x}));
        y2 <= square_q(abs_clamp({y[mbe_pkg::COORD_W-1], y}));
        w  <= square_q(abs_clamp(sum_xy));
      end
      ST_DIVIDE: begin
        rem     <= rem_next;
        quo     <= quo_next;
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == '0) begin
          out_column      <= col;
          out_row         <= row;
          iteration_count <= count;
          green_level     <= (cfg.max_iterations == '0) ? '0 : quo_next;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
`default_nettype none
// ============================================================================
// mandelbrot_escape_time
// Escape-time evaluator: maps a pixel to c and returns its iteration count
// and green level.
// ============================================================================
// A pixel is taken when start is high and busy is low. Its result appears
// for one cycle with done high and cannot be held off. The front end
// registers the index products when it accepts a pixel, then adds the origin
// and writes the point into the queue (two entries); busy stays high until
// then, so it takes no new pixel before the last one is queued, nor while
// the queue is full. The engine pops a pixel, runs each iteration as the
// sums and then three squarings, makes a final test and then runs the
// bit-serial divider, and takes no new pixel before its result is out, so
// that loop sets the rate. Results come out in the order the pixels were
// taken.
module mandelbrot_escape_time (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]   pixel_column,
  input  wire logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]   pixel_row,
  input  wire logic                                   cfg_write,
  input  wire logic [mbe_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                        done,
  output logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]        out_column,
  output logic [mbe_pkg::PIXEL_INDEX_BITS-1:0]        out_row,
  output logic [mbe_pkg::COUNT_W-1:0]                 iteration_count,
  output logic [mbe_pkg::GREEN_W-1:0]                 green_level
);

  mbe_pkg::config_t       cfg;
  mbe_pkg::queue_status_t qstat;
  mbe_pkg::item_t         push_item;
  mbe_pkg::item_t         pop_item;
  logic                   push;
  logic                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x       <= mbe_pkg::ORIGIN_X_RESET;
      cfg.origin_y       <= mbe_pkg::ORIGIN_Y_RESET;
      cfg.step_x         <= mbe_pkg::STEP_X_RESET;
      cfg.step_y         <= mbe_pkg::STEP_Y_RESET;
      cfg.max_iterations <= mbe_pkg::MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbe_pkg::REG_ORIGIN_X:       cfg.origin_x       <= cfg_data;
        mbe_pkg::REG_ORIGIN_Y:       cfg.origin_y       <= cfg_data;
        mbe_pkg::REG_STEP_X:         cfg.step_x         <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_STEP_Y:         cfg.step_y         <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[mbe_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .cfg          (cfg),
    .qstat        (qstat),
    .busy         (busy),
    .push         (push),
    .push_item    (push_item)
  );

  mbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (qstat)
  );

  mbe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .qstat           (qstat),
    .pop_item        (pop_item),
    .pop             (pop),
    .done            (done),
    .out_column      (out_column),
    .out_row         (out_row),
    .iteration_count (iteration_count),
    .green_level     (green_level)
  );

endmodule
`default_nettype wire

FILE: rtl/mbe_checker.sv
`default_nettype none
// ============================================================================
// mbe_checker
// Port-level checks for the escape-time evaluator, bound to the top level.
// ============================================================================
module mbe_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [mbe_pkg::COUNT_W-1:0]   iteration_count,
  input wire logic [mbe_pkg::GREEN_W-1:0]   green_level
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transaction");

  a_done_single_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  a_zero_count_zero_green: assert property (@(posedge clk) disable iff (rst)
    (done && iteration_count == '0) |-> (green_level == '0))
    else $error("nonzero green level for zero iterations");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .iteration_count (iteration_count),
  .green_level     (green_level)
);
`default_nettype wire
